@@ hw/rtl/hse_pkg.sv @@
// ----------------------------------------------------------------------------
// hse_pkg: shared types and constants of the heap sort engine
// Payload structs, controller state codes and the command/status bundles
// that join the controller and the datapath.
// ----------------------------------------------------------------------------
package hse_pkg;

	// Element width and default store depth
	localparam int DATA_W           = 32;
	localparam int MAX_ELEMENTS_DEF = 64;

	// One request on the input channel
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} item_t;

	// One result on the output channel
	typedef struct packed {
		logic signed [DATA_W-1:0] sorted_value;
		logic                     final_res;
	} result_t;

	// Controller states, one-hot
	typedef enum logic [9:0] {
		ST_LOAD     = 10'b00_0000_0001,
		ST_START    = 10'b00_0000_0010,
		ST_BUILD_RD = 10'b00_0000_0100,
		ST_BUILD_LD = 10'b00_0000_1000,
		ST_SIFT_RD  = 10'b00_0001_0000,
		ST_SIFT_CMP = 10'b00_0010_0000,
		ST_EXT_RD   = 10'b00_0100_0000,
		ST_EXT_SWAP = 10'b00_1000_0000,
		ST_EMIT_RD  = 10'b01_0000_0000,
		ST_EMIT_LD  = 10'b10_0000_0000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;       // accepted request: store value, bump count
		logic idx_half;   // idx = count / 2
		logic idx_zero;   // idx = 0
		logic idx_top;    // idx = count - 1
		logic idx_dec;    // idx = idx - 1
		logic idx_inc;    // idx = idx + 1
		logic rd_build;   // read store[idx - 1]
		logic hold_build; // latch sift value, root = idx - 1, size = count
		logic rd_kids;    // read both children of node
		logic sift_end;   // no children: drop held value at node
		logic sift_cmp;   // compare children, move one level
		logic rd_swap;    // read root and store[idx]
		logic swap;       // store[idx] = root, hold old store[idx]
		logic rd_emit;    // read store[idx] for output
		logic emit_ld;    // load output register
		logic clr_cnt;    // run done, empty the store
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic left_in;    // left child inside heap
		logic sift_stop;  // held value not smaller than its children
		logic cnt_ge2;    // at least two elements held
		logic idx_nz;     // idx != 0
		logic idx_gt1;    // idx > 1
		logic emit_last;  // idx is the last element
		logic out_free;   // output register can take a result
	} sts_t;

endpackage

@@ hw/rtl/heap_sort_engine.sv @@
// ----------------------------------------------------------------------------
// heap_sort_engine: in-place max-heap sort of a burst of signed values
//
//   channel   handshake                   payload            role
//   item      item_valid / item_ready     item   (item_t)    value in, last
//   result    result_valid / result_ready result (result_t)  ascending out
//
// Loading accepts one request per cycle while ready. After the request
// marked last, heap build and extraction share one sift unit over the
// element RAM: a sift level reads both children, then compares and writes;
// a build root is read, then latched; an extraction swap reads root and
// heap end, then swaps. A result is read once the output register is free,
// then loaded. Requests beyond MAX_ELEMENTS are dropped. A stalled result
// holds in the output register; the next load starts once the final result
// is registered. Reset clears control state only; no store clearing pass.
// ----------------------------------------------------------------------------
module heap_sort_engine #(
	parameter int MAX_ELEMENTS = hse_pkg::MAX_ELEMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  hse_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output hse_pkg::result_t result
);

	hse_pkg::cmd_t cmd;
	hse_pkg::sts_t sts;

	hse_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_last  (item.last),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	hse_dp #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

@@ hw/rtl/hse_ram.sv @@
// ----------------------------------------------------------------------------
// hse_ram: generic RAM, one write port, two registered read ports
// Contents are undefined after reset.
// ----------------------------------------------------------------------------
module hse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem_q[raddr_a];
		rdata_b <= mem_q[raddr_b];
	end

endmodule

@@ hw/rtl/hse_dp.sv @@
// ----------------------------------------------------------------------------
// hse_dp: heap sort datapath
// Element store, element count, loop index, sift node and held value,
// child compare and the output register.
// ----------------------------------------------------------------------------
module hse_dp #(
	parameter int MAX_ELEMENTS = hse_pkg::MAX_ELEMENTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  hse_pkg::cmd_t    cmd,
	output hse_pkg::sts_t    sts,
	input  hse_pkg::item_t   item,
	output logic             result_valid,
	input  logic             result_ready,
	output hse_pkg::result_t result
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 1);
	localparam int IW = AW + 2;
	localparam int DW = hse_pkg::DATA_W;

	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic [CW-1:0] size_q;
	logic [AW-1:0] node_q;
	logic [DW-1:0] hold_q;
	logic          res_valid_q;
	hse_pkg::result_t res_q;

	logic          full;
	logic [CW-1:0] idx_m1;
	logic [IW-1:0] left_w;
	logic [IW-1:0] right_w;
	logic          left_in;
	logic          right_in;
	logic [DW-1:0] rd_a;
	logic [DW-1:0] rd_b;
	logic          l_gt;
	logic          r_gt;
	logic [DW-1:0] cand;
	logic          stop;
	logic [AW-1:0] child;
	logic [DW-1:0] child_val;
	logic          we;
	logic [AW-1:0] waddr;
	logic [DW-1:0] wdata;
	logic [AW-1:0] raddr_a;
	logic [AW-1:0] raddr_b;

	// Index arithmetic
	assign full     = (cnt_q == CW'(MAX_ELEMENTS));
	assign idx_m1   = idx_q - CW'(1);
	assign left_w   = {1'b0, node_q, 1'b1};
	assign right_w  = left_w + IW'(1);
	assign left_in  = (left_w < IW'(size_q));
	assign right_in = (right_w < IW'(size_q));

	// Child compare: strict greater-than, left first
	assign l_gt      = left_in && ($signed(rd_a) > $signed(hold_q));
	assign cand      = l_gt ? rd_a : hold_q;
	assign r_gt      = right_in && ($signed(rd_b) > $signed(cand));
	assign stop      = !l_gt && !r_gt;
	assign child     = r_gt ? right_w[AW-1:0] : left_w[AW-1:0];
	assign child_val = r_gt ? rd_b : rd_a;

	// Read address select
	always_comb begin
		raddr_a = idx_q[AW-1:0];
		raddr_b = idx_q[AW-1:0];
		if (cmd.rd_build) begin
			raddr_a = idx_m1[AW-1:0];
		end
		if (cmd.rd_kids) begin
			raddr_a = left_w[AW-1:0];
			raddr_b = right_w[AW-1:0];
		end
		if (cmd.rd_swap) begin
			raddr_a = '0;
		end
		// emit reads the element at the loop index
		if (cmd.rd_emit) begin
			raddr_a = idx_q[AW-1:0];
		end
	end

	// Write port select
	always_comb begin
		we    = 1'b0;
		waddr = node_q;
		wdata = hold_q;
		if (cmd.load && !full) begin
			we    = 1'b1;
			waddr = cnt_q[AW-1:0];
			wdata = item.value;
		end
		if (cmd.sift_end) begin
			we = 1'b1;
		end
		if (cmd.sift_cmp) begin
			we = 1'b1;
			if (!stop) begin
				wdata = child_val;
			end
		end
		if (cmd.swap) begin
			we    = 1'b1;
			waddr = idx_q[AW-1:0];
			wdata = rd_a;
		end
	end

	hse_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_ELEMENTS)
	) u_store (
		.clk     (clk),
		.we      (we),
		.waddr   (waddr),
		.wdata   (wdata),
		.raddr_a (raddr_a),
		.rdata_a (rd_a),
		.raddr_b (raddr_b),
		.rdata_b (rd_b)
	);

	// Element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.clr_cnt) begin
			cnt_q <= '0;
		end else if (cmd.load && !full) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// Loop index: build root, heap end, or emit position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_half) begin
			idx_q <= cnt_q >> 1;
		end else if (cmd.idx_zero) begin
			idx_q <= '0;
		end else if (cmd.idx_top) begin
			idx_q <= cnt_q - CW'(1);
		end else if (cmd.idx_dec || cmd.hold_build) begin
			idx_q <= idx_m1;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	// Sift state: node, heap size, value being sifted
	always_ff @(posedge clk) begin
		if (cmd.hold_build) begin
			hold_q <= rd_a;
			node_q <= idx_m1[AW-1:0];
			size_q <= cnt_q;
		end else if (cmd.swap) begin
			hold_q <= rd_b;
			node_q <= '0;
			size_q <= idx_q;
		end else if (cmd.sift_cmp && !stop) begin
			node_q <= child;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			res_q.sorted_value <= rd_a;
			res_q.final_res    <= sts.emit_last;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Status back to the controller
	assign sts.left_in   = left_in;
	assign sts.sift_stop = stop;
	assign sts.cnt_ge2   = (cnt_q >= CW'(2));
	assign sts.idx_nz    = (idx_q != '0);
	assign sts.idx_gt1   = (idx_q > CW'(1));
	assign sts.emit_last = ((idx_q + CW'(1)) == cnt_q);
	assign sts.out_free  = !res_valid_q || result_ready;

endmodule

@@ hw/rtl/hse_ctrl.sv @@
// ----------------------------------------------------------------------------
// hse_ctrl: heap sort controller
// Sequences load, heap build, root extraction and emit, one datapath
// command set per cycle.
// ----------------------------------------------------------------------------
module hse_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_last,
	output logic          item_ready,
	input  hse_pkg::sts_t sts,
	output hse_pkg::cmd_t cmd
);

	hse_pkg::state_t state_q;
	hse_pkg::state_t state_d;
	logic            ext_q;
	logic            ext_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hse_pkg::ST_LOAD;
			ext_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ext_q   <= ext_d;
		end
	end

	assign item_ready = (state_q == hse_pkg::ST_LOAD);

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ext_d   = ext_q;
		cmd     = '0;
		case (state_q)
			hse_pkg::ST_LOAD: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					if (item_last) begin
						state_d = hse_pkg::ST_START;
					end
				end
			end
			hse_pkg::ST_START: begin
				if (sts.cnt_ge2) begin
					cmd.idx_half = 1'b1;
					ext_d        = 1'b0;
					state_d      = hse_pkg::ST_BUILD_RD;
				end else begin
					cmd.idx_zero = 1'b1;
					state_d      = hse_pkg::ST_EMIT_RD;
				end
			end
			hse_pkg::ST_BUILD_RD: begin
				cmd.rd_build = 1'b1;
				state_d      = hse_pkg::ST_BUILD_LD;
			end
			hse_pkg::ST_BUILD_LD: begin
				cmd.hold_build = 1'b1;
				state_d        = hse_pkg::ST_SIFT_RD;
			end
			hse_pkg::ST_SIFT_RD: begin
				cmd.rd_kids = 1'b1;
				if (sts.left_in) begin
					state_d = hse_pkg::ST_SIFT_CMP;
				end else begin
					cmd.sift_end = 1'b1;
				end
			end
			hse_pkg::ST_SIFT_CMP: begin
				cmd.sift_cmp = 1'b1;
				if (!sts.sift_stop) begin
					state_d = hse_pkg::ST_SIFT_RD;
				end
			end
			hse_pkg::ST_EXT_RD: begin
				cmd.rd_swap = 1'b1;
				state_d     = hse_pkg::ST_EXT_SWAP;
			end
			hse_pkg::ST_EXT_SWAP: begin
				cmd.swap = 1'b1;
				state_d  = hse_pkg::ST_SIFT_RD;
			end
			hse_pkg::ST_EMIT_RD: begin
				if (sts.out_free) begin
					cmd.rd_emit = 1'b1;
					state_d     = hse_pkg::ST_EMIT_LD;
				end
			end
			hse_pkg::ST_EMIT_LD: begin
				cmd.emit_ld = 1'b1;
				if (sts.emit_last) begin
					cmd.clr_cnt = 1'b1;
					state_d     = hse_pkg::ST_LOAD;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = hse_pkg::ST_EMIT_RD;
				end
			end
			default: begin
				state_d = hse_pkg::ST_LOAD;
			end
		endcase

		// Sift finished: continue build, start or continue extraction, or emit
		if ((state_q == hse_pkg::ST_SIFT_RD && !sts.left_in) ||
		    (state_q == hse_pkg::ST_SIFT_CMP && sts.sift_stop)) begin
			if (!ext_q) begin
				if (sts.idx_nz) begin
					state_d = hse_pkg::ST_BUILD_RD;
				end else begin
					cmd.idx_top = 1'b1;
					ext_d       = 1'b1;
					state_d     = hse_pkg::ST_EXT_RD;
				end
			end else if (sts.idx_gt1) begin
				cmd.idx_dec = 1'b1;
				state_d     = hse_pkg::ST_EXT_RD;
			end else begin
				cmd.idx_zero = 1'b1;
				state_d      = hse_pkg::ST_EMIT_RD;
			end
		end
	end

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: self-checking bench for heap_sort_engine
// Sends bursts of signed values, each closed by a request marked last, and
// checks that every burst comes back in ascending order with the final
// result flagged. Covers single-element bursts, extremes, duplicates, a
// full store and bursts that overflow the store. Both channels stall at
// random, and one long output hold-off backs the block up.
// ----------------------------------------------------------------------------
module testbench;

	localparam int STORE_DEPTH   = hse_pkg::MAX_ELEMENTS_DEF;
	localparam int HOLD_LEN      = 2000;
	localparam int STALL_LIMIT   = 20000;
	localparam int DRAIN_CYCLES  = 100;
	localparam int PHASE_BUDGET  = 130;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	hse_pkg::item_t   item;
	logic             result_valid;
	logic             result_ready;
	hse_pkg::result_t result;

	// stimulus and prediction state
	hse_pkg::item_t                    pending_items[$];
	hse_pkg::result_t                  expected_sorted[$];
	logic signed [hse_pkg::DATA_W-1:0] burst_vals[STORE_DEPTH];
	int                                burst_cnt;
	int                                mismatches;
	int                                send_gap_pct;
	int                                recv_gap_pct;
	logic                              hold_trigger;
	int                                hold_cycles;
	int                                quiet_cycles;

	heap_sort_engine u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Take one accepted request; on last, sort the burst and queue results
	task automatic absorb_element(input hse_pkg::item_t req);
		logic signed [hse_pkg::DATA_W-1:0] v;
		hse_pkg::result_t r;
		int i;
		int j;
		if (burst_cnt < STORE_DEPTH) begin
			burst_vals[burst_cnt] = req.value;
			burst_cnt++;
		end
		if (req.last) begin
			for (i = 1; i < burst_cnt; i++) begin
				v = burst_vals[i];
				j = i - 1;
				while (j >= 0 && burst_vals[j] > v) begin
					burst_vals[j + 1] = burst_vals[j];
					j--;
				end
				burst_vals[j + 1] = v;
			end
			for (i = 0; i < burst_cnt; i++) begin
				r.sorted_value = burst_vals[i];
				r.final_res    = (i == burst_cnt - 1);
				expected_sorted.push_back(r);
			end
			burst_cnt = 0;
		end
	endtask

	// Compare one result with the oldest expected one
	task automatic check_result(input hse_pkg::result_t got);
		hse_pkg::result_t want;
		if (expected_sorted.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result: sorted_value=%0d final_res=%0b",
					got.sorted_value, got.final_res);
		end else begin
			want = expected_sorted.pop_front();
			if (got.sorted_value !== want.sorted_value || got.final_res !== want.final_res) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: sorted_value exp %0d got %0d, final_res exp %0b got %0b",
						want.sorted_value, got.sorted_value, want.final_res, got.final_res);
			end
		end
	endtask

	// Random element: mostly full range, some extremes, some small duplicates
	function automatic logic signed [hse_pkg::DATA_W-1:0] pick_value();
		case ($urandom_range(9))
			0:       return 32'sh7FFF_FFFF;
			1:       return 32'sh8000_0000;
			2, 3:    return $urandom_range(16) - 8;
			default: return $urandom;
		endcase
	endfunction

	task automatic queue_burst(input int len);
		hse_pkg::item_t req;
		int i;
		for (i = 0; i < len; i++) begin
			req.value = pick_value();
			req.last  = (i == len - 1);
			pending_items.push_back(req);
		end
	endtask

	task automatic queue_fixed(input logic signed [hse_pkg::DATA_W-1:0] v, input logic lst);
		hse_pkg::item_t req;
		req.value = v;
		req.last  = lst;
		pending_items.push_back(req);
	endtask

	// One phase of random bursts, opened by a burst of the given length
	task automatic queue_random_phase(input int first_len);
		int sent;
		int len;
		sent = first_len;
		if (first_len > 0)
			queue_burst(first_len);
		while (sent < PHASE_BUDGET) begin
			if ($urandom_range(19) == 0)
				len = $urandom_range(STORE_DEPTH + 3, 13);
			else
				len = $urandom_range(12, 1);
			queue_burst(len);
			sent += len;
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || expected_sorted.size() != 0)
			@(negedge clk);
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item       <= '0;
		end else if (!item_valid || item_ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				item       <= pending_items.pop_front();
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Result receiver, with one long hold-off once triggered
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			hold_cycles  <= 0;
		end else if (hold_trigger && hold_cycles < HOLD_LEN) begin
			result_ready <= 1'b0;
			hold_cycles  <= hold_cycles + 1;
		end else begin
			result_ready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Monitor: predict on accepted requests, check accepted results
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready)
				absorb_element(item);
			if (result_valid && result_ready)
				check_result(result);
		end
	end

	// Watchdog on cycles with no handshake on either channel
	always @(posedge clk) begin
		if (arst_n && !(item_valid && item_ready) && !(result_valid && result_ready))
			quiet_cycles <= quiet_cycles + 1;
		else
			quiet_cycles <= 0;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("[heap_sort_engine] ERROR");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		burst_cnt    = 0;
		mismatches   = 0;
		hold_trigger = 1'b0;
		send_gap_pct = 22;
		recv_gap_pct = 68;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: single element, extremes, duplicates, reversed, all equal
		queue_fixed(32'sh7FFF_FFFF, 1'b1);
		queue_fixed(32'sh7FFF_FFFF, 1'b0);
		queue_fixed(32'sh8000_0000, 1'b1);
		queue_fixed(-1, 1'b0);
		queue_fixed(0, 1'b0);
		queue_fixed(1, 1'b0);
		queue_fixed(32'sh8000_0000, 1'b0);
		queue_fixed(32'sh7FFF_FFFF, 1'b0);
		queue_fixed(0, 1'b1);
		queue_fixed(50, 1'b0);
		queue_fixed(40, 1'b0);
		queue_fixed(30, 1'b0);
		queue_fixed(-20, 1'b0);
		queue_fixed(-30, 1'b1);
		queue_fixed(3, 1'b0);
		queue_fixed(3, 1'b0);
		queue_fixed(3, 1'b0);
		queue_fixed(3, 1'b1);

		// phase one: opens with a burst that overflows the store, last three dropped
		queue_random_phase(STORE_DEPTH + 3);
		wait_drained();

		// phase two: stalls swapped, opens with a burst that fills the store
		send_gap_pct = 68;
		recv_gap_pct = 22;
		queue_random_phase(STORE_DEPTH);
		wait_drained();

		// phase three: no idling, long output hold-off backs up the input
		send_gap_pct = 0;
		recv_gap_pct = 0;
		hold_trigger = 1'b1;
		queue_random_phase(0);
		wait_drained();

		repeat (DRAIN_CYCLES) @(posedge clk);
		mismatches += expected_sorted.size();
		if (mismatches == 0)
			$display("[heap_sort_engine] OK");
		else
			$display("[heap_sort_engine] ERROR");
		$finish;
	end

endmodule

@@ heap_sort_engine.f @@
hw/rtl/hse_pkg.sv
hw/rtl/hse_ram.sv
hw/rtl/hse_dp.sv
hw/rtl/hse_ctrl.sv
hw/rtl/heap_sort_engine.sv
bench/testbench.sv
